// ===== rtl/prer_pkg.sv =====
// Package for the per-process event rule engine: command, rule and register codes,
// and the shared window-count rule. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package prer_pkg;

	localparam logic [1:0] CMD_EXEC    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_CONNECT = 2'd2;
	localparam logic [1:0] CMD_EXIT    = 2'd3;

	localparam logic [1:0] RULE_UNSIGNED   = 2'd0;
	localparam logic [1:0] RULE_EXEC       = 2'd1;
	localparam logic [1:0] RULE_BEACON     = 2'd2;
	localparam logic [1:0] RULE_CONN_BURST = 2'd3;

	localparam logic [2:0] REG_EXEC_LIMIT   = 3'd0;
	localparam logic [2:0] REG_EXEC_WINDOW  = 3'd1;
	localparam logic [2:0] REG_BEACON_GAPS  = 3'd2;
	localparam logic [2:0] REG_BEACON_TOL   = 3'd3;
	localparam logic [2:0] REG_FANOUT_LIMIT = 3'd4;
	localparam logic [2:0] REG_FANOUT_WIN   = 3'd5;

	localparam logic [9:0] CNT_MAX   = 10'd1023;
	localparam logic [38:0] PCT_FULL = 39'd100;

	typedef struct packed {
		logic        fire;
		logic [9:0]  cnt;
		logic [31:0] begin_s;
		logic [9:0]  acnt;
		logic [31:0] elapsed;
	} win_res_t;

	// Counts one event in a window; a window that has run out, or that starts after
	// now, restarts with a count of one; a count above the limit fires and clears to 0.
	function automatic win_res_t win_rule(input logic [9:0] cnt, input logic [31:0] beg,
			input logic [31:0] now, input logic [15:0] win, input logic [9:0] limit);
		win_res_t r;
		logic [9:0] inc;
		logic [31:0] el;
		el = now - beg;
		r.fire = 1'b0;
		r.acnt = 10'd0;
		r.elapsed = 32'd0;
		if (now < beg || el > {16'd0, win}) begin
			r.cnt = 10'd1;
			r.begin_s = now;
		end else begin
			inc = (cnt < CNT_MAX) ? cnt + 10'd1 : cnt;
			if (inc > limit) begin
				r.fire = 1'b1;
				r.acnt = inc;
				r.elapsed = el;
				r.cnt = 10'd0;
				r.begin_s = now;
			end else begin
				r.cnt = inc;
				r.begin_s = beg;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/prer_mem.sv =====
// Simple dual-port synchronous memory with registered read data.
// Used for the slot records and the beacon ring; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module prer_mem #(
	parameter int WIDTH = 8,
	parameter int AW = 8
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [1 << AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/prer_div.sv =====
// Restoring divider, one quotient bit per cycle, for the mean beacon gap.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module prer_div #(
	parameter int DW = 35,
	parameter int VW = 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic      [DW-1:0] quot
);
	localparam int CTW = $clog2(DW + 1);

	logic [DW-1:0]  quo_q;
	logic [VW-1:0]  rem_q;
	logic [CTW-1:0] cnt_q;
	logic           done_q;
	logic [VW:0]    shifted;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign done = done_q;
	assign quot = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q <= dividend;
				rem_q <= '0;
				cnt_q <= CTW'(DW);
			end else if (cnt_q != '0) begin
				if (shifted >= {1'b0, divisor}) begin
					rem_q <= VW'(shifted - {1'b0, divisor});
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= shifted[VW-1:0];
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CTW'(1);
				if (cnt_q == CTW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/per_process_event_rule_engine_top.sv =====
// Per-process event rule engine: one item at a time, slot records and beacon ring
// in synchronous memories. An exec that migrates a source slot first reads that slot;
// an internet connect with the beacon check reads the ring entries in turn, divides
// the summed gaps by the gap count and checks each gap against the mean. Each alert
// leaves through the output register, which waits on m_axis_tready. Reset clears slot
// valid bits, registers to defaults, control.
`timescale 1ns / 1ps
`default_nettype none
module per_process_event_rule_engine_top import prer_pkg::*; #(
	parameter int SLOT_COUNT = 256,
	parameter int RING_DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// slot[7:0], source_slot[15:8], source_valid[16], now_s[48:17],
	// platform_bin[49], path_in_tmp[50], is_inet[51], zero fill
	input  wire logic [55:0] s_axis_tdata,
	// command[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// alert_slot[7:0], event_count[17:8], interval_s[49:18], zero fill
	output logic      [55:0] m_axis_tdata,
	// rule[1:0]
	output logic      [1:0]  m_axis_tuser,
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam int SIDX = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int RIDX = $clog2(RING_DEPTH);
	localparam int CW = RIDX + 1;
	localparam int SW = 32 + RIDX;

	typedef struct packed {
		logic            plat;
		logic            tmp;
		logic [9:0]      ecnt;
		logic [31:0]     ebeg;
		logic [9:0]      ccnt;
		logic [31:0]     cbeg;
		logic [RIDX-1:0] wptr;
		logic [CW-1:0]   bcnt;
	} rec_t;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DEC   = 4'd1;
	localparam logic [3:0] ST_RSRC  = 4'd2;
	localparam logic [3:0] ST_RWAIT = 4'd3;
	localparam logic [3:0] ST_BWR   = 4'd4;
	localparam logic [3:0] ST_BRD   = 4'd5;
	localparam logic [3:0] ST_BCAP  = 4'd6;
	localparam logic [3:0] ST_BDIV  = 4'd7;
	localparam logic [3:0] ST_BDIVW = 4'd8;
	localparam logic [3:0] ST_BPROD = 4'd9;
	localparam logic [3:0] ST_BCHK  = 4'd10;
	localparam logic [3:0] ST_WB    = 4'd11;
	localparam logic [3:0] ST_EMIT  = 4'd12;

	logic [3:0] state_q;

	logic [9:0]  exec_limit_q, fanout_limit_q;
	logic [15:0] exec_window_q, fanout_window_q;
	logic [2:0]  min_gaps_q;
	logic [6:0]  tol_pct_q;

	logic [1:0]  cmd_q;
	logic [7:0]  slot_q, src_q;
	logic        srcv_q, plat_q, tmp_in_q, inet_q, mig_q;
	logic [31:0] now_q;

	logic [SLOT_COUNT-1:0] valid_q, valid_wb;
	rec_t rec_q, src_rec_q, rd_rec, base_rec, upd_rec, ring_rec, clr_rec;
	logic [$bits(rec_t)-1:0] rec_rdata;

	logic [3:0]  pend_q, upd_pend;
	logic [9:0]  win_cnt_q;
	logic [31:0] win_el_q, mean_q;
	logic [CW-1:0] n_q, k_q, j_q, start_q;
	logic [31:0] prev_q;
	logic [SW-1:0] sum_q;
	logic        neg_q;
	logic [31:0] gaps_q [RING_DEPTH];
	logic [38:0] prod_q;

	logic        o_valid_q, o_last_q;
	logic [1:0]  o_rule_q;
	logic [7:0]  o_slot_q;
	logic [9:0]  o_cnt_q;
	logic [31:0] o_int_q;

	logic [SIDX-1:0] sidx, srcidx;
	logic in_range, src_in_range, mig_now;
	logic rec_re;
	logic [SIDX-1:0] rec_raddr;
	logic [31:0] ring_rdata;
	logic [CW-1:0] pos_sum, pos;
	logic [RIDX-1:0] wp_next;
	logic [CW-1:0] cnt_new, st_sum, st_mod;
	logic beacon_go;
	logic div_start, div_done;
	logic [SW-1:0] div_quot;
	logic [31:0] gap_cur, dev;
	logic [38:0] dev100;
	win_res_t ex_res, fo_res;
	logic [3:0] selbit;
	logic emit_go;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tdata = {6'd0, o_int_q, o_cnt_q, o_slot_q};
	assign m_axis_tuser = o_rule_q;
	assign m_axis_tlast = o_last_q;

	assign sidx = SIDX'(slot_q);
	assign srcidx = SIDX'(src_q);
	assign in_range = (32'(slot_q) < 32'(SLOT_COUNT));
	assign src_in_range = (32'(src_q) < 32'(SLOT_COUNT));
	assign mig_now = (cmd_q == CMD_EXEC) && srcv_q && src_in_range && (src_q != slot_q)
		&& valid_q[srcidx];

	assign rec_re = (state_q == ST_DEC && in_range && cmd_q != CMD_EXIT)
		|| state_q == ST_RSRC;
	assign rec_raddr = (state_q == ST_DEC && mig_now) ? srcidx : sidx;
	assign rd_rec = rec_t'(rec_rdata);

	prer_mem #(.WIDTH($bits(rec_t)), .AW(SIDX)) u_rec_mem (
		.clk(clk), .we(state_q == ST_WB), .waddr(sidx), .wdata(rec_q),
		.re(rec_re), .raddr(rec_raddr), .rdata(rec_rdata)
	);

	// Ring position of the k-th oldest entry.
	assign pos_sum = start_q + k_q;
	assign pos = (pos_sum >= CW'(RING_DEPTH)) ? pos_sum - CW'(RING_DEPTH) : pos_sum;

	prer_mem #(.WIDTH(32), .AW(SIDX + RIDX)) u_ring_mem (
		.clk(clk), .we(state_q == ST_BWR), .waddr({sidx, rec_q.wptr}), .wdata(now_q),
		.re(state_q == ST_BRD), .raddr({sidx, pos[RIDX-1:0]}), .rdata(ring_rdata)
	);

	assign div_start = (state_q == ST_BDIV) && !neg_q && (sum_q != '0);

	prer_div #(.DW(SW), .VW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_q),
		.divisor(n_q - CW'(1)), .done(div_done), .quot(div_quot)
	);

	always_comb begin
		base_rec = '0;
		base_rec.ebeg = now_q;
		if (valid_q[sidx]) begin
			base_rec = rd_rec;
		end
		if (mig_q) begin
			base_rec.ecnt = src_rec_q.ecnt;
			base_rec.ebeg = src_rec_q.ebeg;
			base_rec.tmp = src_rec_q.tmp;
		end
		base_rec.plat = plat_q;
	end

	assign ex_res = win_rule(base_rec.ecnt, base_rec.ebeg, now_q, exec_window_q,
		exec_limit_q);
	assign fo_res = win_rule(base_rec.ccnt, base_rec.cbeg, now_q, fanout_window_q,
		fanout_limit_q);

	always_comb begin
		upd_rec = base_rec;
		upd_pend = '0;
		case (cmd_q)
			CMD_EXEC: begin
				upd_rec.ecnt = ex_res.cnt;
				upd_rec.ebeg = ex_res.begin_s;
				upd_pend[1] = ex_res.fire;
			end
			CMD_WRITE: begin
				upd_rec.tmp = base_rec.tmp | tmp_in_q;
			end
			CMD_CONNECT: begin
				if (inet_q) begin
					upd_rec.ccnt = fo_res.cnt;
					upd_rec.cbeg = fo_res.begin_s;
					upd_pend[0] = !plat_q && base_rec.tmp;
					upd_pend[3] = fo_res.fire;
				end
			end
			default: ;
		endcase
	end

	assign wp_next = (rec_q.wptr == RIDX'(RING_DEPTH - 1)) ? '0 : rec_q.wptr + RIDX'(1);
	assign cnt_new = (rec_q.bcnt < CW'(RING_DEPTH)) ? rec_q.bcnt + CW'(1) : rec_q.bcnt;
	assign beacon_go = (5'(cnt_new) >= 5'(min_gaps_q) + 5'd1) && (cnt_new >= CW'(2));
	assign st_sum = CW'(wp_next) + CW'(RING_DEPTH) - cnt_new;
	assign st_mod = (st_sum >= CW'(RING_DEPTH)) ? st_sum - CW'(RING_DEPTH) : st_sum;

	always_comb begin
		ring_rec = rec_q;
		ring_rec.wptr = wp_next;
		ring_rec.bcnt = cnt_new;
		clr_rec = rec_q;
		clr_rec.wptr = '0;
		clr_rec.bcnt = '0;
	end

	always_comb begin
		valid_wb = valid_q;
		valid_wb[sidx] = 1'b1;
		if (mig_q) begin
			valid_wb[srcidx] = 1'b0;
		end
	end

	assign gap_cur = gaps_q[j_q[RIDX-1:0]];
	assign dev = (gap_cur >= mean_q) ? gap_cur - mean_q : mean_q - gap_cur;
	// dev > floor(mean * pct / 100) is the same as 100 * dev > mean * pct.
	assign dev100 = {7'd0, dev} * PCT_FULL;

	always_comb begin
		selbit = 4'b1000;
		if (pend_q[0]) begin
			selbit = 4'b0001;
		end else if (pend_q[1]) begin
			selbit = 4'b0010;
		end else if (pend_q[2]) begin
			selbit = 4'b0100;
		end
	end

	assign emit_go = (state_q == ST_EMIT) && (!o_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_limit_q <= 10'd3;
			exec_window_q <= 16'd5;
			min_gaps_q <= 3'd5;
			tol_pct_q <= 7'd30;
			fanout_limit_q <= 10'd10;
			fanout_window_q <= 16'd30;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_EXEC_LIMIT:   exec_limit_q <= cfg_data[9:0];
				REG_EXEC_WINDOW:  exec_window_q <= cfg_data;
				REG_BEACON_GAPS:  min_gaps_q <= cfg_data[2:0];
				REG_BEACON_TOL:   tol_pct_q <= cfg_data[6:0];
				REG_FANOUT_LIMIT: fanout_limit_q <= cfg_data[9:0];
				REG_FANOUT_WIN:   fanout_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_BCAP && k_q != '0) begin
			gaps_q[RIDX'(k_q - CW'(1))] <= ring_rdata - prev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			pend_q <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				o_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q <= s_axis_tuser;
						slot_q <= s_axis_tdata[7:0];
						src_q <= s_axis_tdata[15:8];
						srcv_q <= s_axis_tdata[16];
						now_q <= s_axis_tdata[48:17];
						plat_q <= s_axis_tdata[49];
						tmp_in_q <= s_axis_tdata[50];
						inet_q <= s_axis_tdata[51];
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					mig_q <= mig_now;
					pend_q <= '0;
					if (!in_range) begin
						state_q <= ST_IDLE;
					end else if (cmd_q == CMD_EXIT) begin
						valid_q[sidx] <= 1'b0;
						state_q <= ST_IDLE;
					end else if (mig_now) begin
						state_q <= ST_RSRC;
					end else begin
						state_q <= ST_RWAIT;
					end
				end
				ST_RSRC: begin
					src_rec_q <= rd_rec;
					state_q <= ST_RWAIT;
				end
				ST_RWAIT: begin
					rec_q <= upd_rec;
					pend_q <= upd_pend;
					win_cnt_q <= (cmd_q == CMD_EXEC) ? ex_res.acnt : fo_res.acnt;
					win_el_q <= (cmd_q == CMD_EXEC) ? ex_res.elapsed : fo_res.elapsed;
					state_q <= (cmd_q == CMD_CONNECT && inet_q) ? ST_BWR : ST_WB;
				end
				ST_BWR: begin
					rec_q <= ring_rec;
					n_q <= cnt_new;
					start_q <= st_mod;
					k_q <= '0;
					sum_q <= '0;
					neg_q <= 1'b0;
					state_q <= beacon_go ? ST_BRD : ST_WB;
				end
				ST_BRD: begin
					state_q <= ST_BCAP;
				end
				ST_BCAP: begin
					if (k_q != '0) begin
						if (ring_rdata < prev_q) begin
							neg_q <= 1'b1;
						end
						sum_q <= sum_q + SW'(ring_rdata - prev_q);
					end
					prev_q <= ring_rdata;
					k_q <= k_q + CW'(1);
					state_q <= (k_q + CW'(1) == n_q) ? ST_BDIV : ST_BRD;
				end
				ST_BDIV: begin
					state_q <= div_start ? ST_BDIVW : ST_WB;
				end
				ST_BDIVW: begin
					if (div_done) begin
						mean_q <= div_quot[31:0];
						state_q <= ST_BPROD;
					end
				end
				ST_BPROD: begin
					prod_q <= {7'd0, mean_q} * {32'd0, tol_pct_q};
					j_q <= '0;
					state_q <= ST_BCHK;
				end
				ST_BCHK: begin
					if (dev100 > prod_q) begin
						state_q <= ST_WB;
					end else if (j_q + CW'(1) == n_q - CW'(1)) begin
						rec_q <= clr_rec;
						pend_q <= pend_q | 4'b0100;
						state_q <= ST_WB;
					end
					j_q <= j_q + CW'(1);
				end
				ST_WB: begin
					valid_q <= valid_wb;
					state_q <= (pend_q != '0) ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (emit_go) begin
						o_slot_q <= slot_q;
						o_last_q <= ((pend_q & ~selbit) == '0);
						pend_q <= pend_q & ~selbit;
						case (selbit)
							4'b0001: begin
								o_rule_q <= RULE_UNSIGNED;
								o_cnt_q <= '0;
								o_int_q <= '0;
							end
							4'b0010: begin
								o_rule_q <= RULE_EXEC;
								o_cnt_q <= win_cnt_q;
								o_int_q <= win_el_q;
							end
							4'b0100: begin
								o_rule_q <= RULE_BEACON;
								o_cnt_q <= 10'(n_q);
								o_int_q <= mean_q;
							end
							default: begin
								o_rule_q <= RULE_CONN_BURST;
								o_cnt_q <= win_cnt_q;
								o_int_q <= win_el_q;
							end
						endcase
						if ((pend_q & ~selbit) == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== tb/per_process_event_rule_engine_top_test.sv =====
// Self-checking testbench for the per-process event rule engine top level.
// Drives events and register writes, predicts alerts in SystemVerilog; needs prer_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none
module per_process_event_rule_engine_top_test;
	import prer_pkg::*;

	localparam logic [2:0] REG_SPARE = 3'd6;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int SLOTS = 256;
	localparam int RING = 8;

	typedef struct {
		logic [1:0]  cmd;
		logic [7:0]  slot;
		logic [7:0]  src;
		logic        src_ok;
		logic [31:0] now;
		logic        plat;
		logic        tmp;
		logic        inet;
	} event_t;

	typedef struct {
		logic [1:0]  rule;
		logic [7:0]  slot;
		logic [9:0]  cnt;
		logic [31:0] ival;
		logic        last;
	} alert_t;

	typedef struct {
		event_t     ev;
		int         n_alerts;
		logic [1:0] first_rule;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid, s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
	logic [55:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	per_process_event_rule_engine_top DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state: settings and per-slot records.
	logic [9:0]  exec_limit_q;
	logic [15:0] exec_win_q;
	logic [2:0]  min_gaps_q;
	logic [6:0]  tol_pct_q;
	logic [9:0]  fan_limit_q;
	logic [15:0] fan_win_q;
	bit          live[SLOTS];
	bit          platform[SLOTS];
	bit          tmp_seen[SLOTS];
	logic [9:0]  exec_cnt[SLOTS];
	logic [31:0] exec_begin[SLOTS];
	logic [9:0]  conn_cnt[SLOTS];
	logic [31:0] conn_begin[SLOTS];
	logic [31:0] ring_time[SLOTS][RING];
	logic [2:0]  ring_wr[SLOTS];
	logic [3:0]  ring_fill[SLOTS];

	alert_t expected_alerts[$];
	int errors = 0;
	int items_sent = 0;
	int alerts_seen = 0;
	int rule_hits[4] = '{0, 0, 0, 0};
	int send_idle = 0;
	int recv_idle = 0;
	logic [31:0] clock_s = 32'd1000;

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic void touch(input int s, input logic [31:0] now);
		if (!live[s]) begin
			live[s] = 1'b1;
			platform[s] = 1'b0;
			tmp_seen[s] = 1'b0;
			exec_cnt[s] = '0;
			exec_begin[s] = now;
			conn_cnt[s] = '0;
			conn_begin[s] = '0;
			ring_wr[s] = '0;
			ring_fill[s] = '0;
		end
	endfunction

	function automatic bit count_in_window(inout logic [9:0] cnt, inout logic [31:0] beg,
			input logic [31:0] now, input logic [15:0] win, input logic [9:0] lim,
			output logic [9:0] acnt, output logic [31:0] el);
		acnt = '0;
		el = '0;
		if (now < beg || now - beg > {16'd0, win}) begin
			cnt = 10'd1;
			beg = now;
			return 1'b0;
		end
		if (cnt != 10'd1023) cnt = cnt + 10'd1;
		if (cnt > lim) begin
			acnt = cnt;
			el = now - beg;
			cnt = '0;
			beg = now;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Stores the connect time and checks that all gaps stay near their mean.
	function automatic bit beacon_check(input int s, input logic [31:0] now,
			output logic [9:0] acnt, output logic [31:0] mean_out);
		int n, start, ng;
		logic [31:0] gaps[RING];
		logic [31:0] a, b;
		logic [63:0] sum, mean, tol, dev;
		acnt = '0;
		mean_out = '0;
		ring_time[s][ring_wr[s]] = now;
		ring_wr[s] = ring_wr[s] + 3'd1;
		if (ring_fill[s] < RING) ring_fill[s] = ring_fill[s] + 4'd1;
		n = ring_fill[s];
		if (n < int'(min_gaps_q) + 1 || n < 2) return 1'b0;
		start = (int'(ring_wr[s]) + RING - n) % RING;
		ng = n - 1;
		sum = '0;
		for (int i = 0; i < ng; i++) begin
			a = ring_time[s][(start + i) % RING];
			b = ring_time[s][(start + i + 1) % RING];
			if (b < a) return 1'b0;
			gaps[i] = b - a;
			sum += gaps[i];
		end
		if (sum == 0) return 1'b0;
		mean = sum / ng;
		tol = mean * tol_pct_q / 100;
		for (int i = 0; i < ng; i++) begin
			dev = (gaps[i] >= mean) ? gaps[i] - mean : mean - gaps[i];
			if (dev > tol) return 1'b0;
		end
		acnt = n[9:0];
		mean_out = mean[31:0];
		ring_fill[s] = '0;
		ring_wr[s] = '0;
		return 1'b1;
	endfunction

	// Applies one event to the predictor, queues its alerts, returns how many.
	function automatic int predict_alerts(input event_t e, output logic [1:0] first_rule);
		alert_t found[$];
		logic [9:0] acnt;
		logic [31:0] aval;
		int s;
		bit mig;
		s = e.slot;
		first_rule = '0;
		case (e.cmd)
			CMD_EXEC: begin
				mig = e.src_ok && e.src != e.slot && live[e.src];
				touch(s, e.now);
				if (mig) begin
					exec_cnt[s] = exec_cnt[e.src];
					exec_begin[s] = exec_begin[e.src];
					tmp_seen[s] = tmp_seen[e.src];
					live[e.src] = 1'b0;
				end
				platform[s] = e.plat;
				if (count_in_window(exec_cnt[s], exec_begin[s], e.now, exec_win_q,
						exec_limit_q, acnt, aval))
					found.push_back('{RULE_EXEC, e.slot, acnt, aval, 1'b0});
			end
			CMD_WRITE: begin
				touch(s, e.now);
				platform[s] = e.plat;
				if (e.tmp) tmp_seen[s] = 1'b1;
			end
			CMD_CONNECT: begin
				touch(s, e.now);
				platform[s] = e.plat;
				if (e.inet) begin
					if (!platform[s] && tmp_seen[s])
						found.push_back('{RULE_UNSIGNED, e.slot, 10'd0, 32'd0, 1'b0});
					if (beacon_check(s, e.now, acnt, aval))
						found.push_back('{RULE_BEACON, e.slot, acnt, aval, 1'b0});
					if (count_in_window(conn_cnt[s], conn_begin[s], e.now, fan_win_q,
							fan_limit_q, acnt, aval))
						found.push_back('{RULE_CONN_BURST, e.slot, acnt, aval, 1'b0});
				end
			end
			default: live[s] = 1'b0;
		endcase
		if (found.size() > 0) begin
			found[found.size() - 1].last = 1'b1;
			first_rule = found[0].rule;
		end
		foreach (found[i]) expected_alerts.push_back(found[i]);
		return found.size();
	endfunction

	task automatic send_event(input event_t e, output int n, output logic [1:0] first_rule);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= e.cmd;
		s_axis_tdata <= {4'd0, e.inet, e.tmp, e.plat, e.now, e.src_ok, e.src, e.slot};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		n = predict_alerts(e, first_rule);
		items_sent++;
	endtask

	task automatic send(input event_t e);
		int n;
		logic [1:0] r;
		send_event(e, n, r);
	endtask

	// Waits for every queued alert, then for the longest beacon pass to drain.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_alerts.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_EXEC_LIMIT:   exec_limit_q = val[9:0];
			REG_EXEC_WINDOW:  exec_win_q = val;
			REG_BEACON_GAPS:  min_gaps_q = val[2:0];
			REG_BEACON_TOL:   tol_pct_q = val[6:0];
			REG_FANOUT_LIMIT: fan_limit_q = val[9:0];
			REG_FANOUT_WIN:   fan_win_q = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input logic [15:0] el, input logic [15:0] ew,
			input logic [15:0] bg, input logic [15:0] bt, input logic [15:0] fl,
			input logic [15:0] fw);
		write_reg(REG_EXEC_LIMIT, el);
		write_reg(REG_EXEC_WINDOW, ew);
		write_reg(REG_BEACON_GAPS, bg);
		write_reg(REG_BEACON_TOL, bt);
		write_reg(REG_FANOUT_LIMIT, fl);
		write_reg(REG_FANOUT_WIN, fw);
	endtask

	function automatic event_t mk(input logic [1:0] cmd, input logic [7:0] slot,
			input logic [31:0] now, input logic plat = 1'b1, input logic inet = 1'b1,
			input logic tmp = 1'b0, input logic [7:0] src = 8'd0, input logic src_ok = 1'b0);
		event_t e;
		e = '{cmd, slot, src, src_ok, now, plat, tmp, inet};
		return e;
	endfunction

	function automatic logic [7:0] pool_slot();
		return 8'($urandom_range(0, 5));
	endfunction

	// Mostly well-formed sequences on a few slots, with some noise mixed in.
	task automatic run_random(input int count);
		int stop, len, period, kind;
		logic [7:0] s;
		event_t e;
		stop = items_sent + count;
		while (items_sent < stop) begin
			kind = $urandom_range(99);
			s = pool_slot();
			if (kind < 30) begin
				len = $urandom_range(3, 9);
				period = $urandom_range(1, 20);
				for (int i = 0; i < len; i++) begin
					clock_s += period + (($urandom_range(3) == 0) ? $urandom_range(2) : 0);
					send(mk(CMD_CONNECT, s, clock_s, $urandom_range(3) != 0, 1'b1,
						1'b0));
				end
			end else if (kind < 50) begin
				len = $urandom_range(2, 6);
				for (int i = 0; i < len; i++) begin
					clock_s += $urandom_range(2);
					send(mk(CMD_EXEC, s, clock_s, 1'($urandom_range(1)), 1'b0, 1'b0,
						pool_slot(), $urandom_range(3) == 0));
				end
			end else if (kind < 70) begin
				clock_s += $urandom_range(3);
				send(mk(CMD_WRITE, s, clock_s, 1'b0, 1'b0, 1'b1));
				clock_s += $urandom_range(3);
				send(mk(CMD_CONNECT, s, clock_s, 1'b0, 1'b1));
			end else if (kind < 85) begin
				clock_s += $urandom_range(4);
				e = mk(2'($urandom_range(3)), s, clock_s, 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'($urandom_range(1)), pool_slot(),
					1'($urandom_range(1)));
				send(e);
			end else begin
				e = mk(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom(),
					1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
					8'($urandom_range(255)), 1'($urandom_range(1)));
				send(e);
			end
		end
	endtask

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle);

	// Values are stable at the falling edge; a handshake seen here completes at the next rise.
	always @(negedge clk) begin
		alert_t x;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			alerts_seen++;
			rule_hits[m_axis_tuser]++;
			if (expected_alerts.size() == 0) begin
				report($sformatf("unexpected alert rule %0d slot %0d", m_axis_tuser,
					m_axis_tdata[7:0]));
			end else begin
				x = expected_alerts.pop_front();
				if (m_axis_tuser !== x.rule)
					report($sformatf("rule %0d, want %0d", m_axis_tuser, x.rule));
				if (m_axis_tdata[7:0] !== x.slot)
					report($sformatf("slot %0d, want %0d", m_axis_tdata[7:0], x.slot));
				if (m_axis_tdata[17:8] !== x.cnt)
					report($sformatf("count %0d, want %0d", m_axis_tdata[17:8], x.cnt));
				if (m_axis_tdata[49:18] !== x.ival)
					report($sformatf("interval %0d, want %0d", m_axis_tdata[49:18], x.ival));
				if (m_axis_tlast !== x.last)
					report($sformatf("last %0b, want %0b", m_axis_tlast, x.last));
			end
		end
	end

	initial begin
		#3ms;
		$display("timeout with %0d alerts outstanding", expected_alerts.size());
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		row_t rows[$];
		int n;
		logic [1:0] r;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		exec_limit_q = 10'd3;
		exec_win_q = 16'd5;
		min_gaps_q = 3'd5;
		tol_pct_q = 7'd30;
		fan_limit_q = 10'd10;
		fan_win_q = 16'd30;
		foreach (live[i]) live[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 13;
		recv_idle = 48;
		// Exec burst on the fourth exec within the window.
		rows.push_back('{mk(CMD_EXEC, 8'd0, 32'd100), 0, RULE_EXEC});
		rows.push_back('{mk(CMD_EXEC, 8'd0, 32'd101), 0, RULE_EXEC});
		rows.push_back('{mk(CMD_EXEC, 8'd0, 32'd102), 0, RULE_EXEC});
		rows.push_back('{mk(CMD_EXEC, 8'd0, 32'd103), 1, RULE_EXEC});
		// Unsigned process writes to tmp, then connects.
		rows.push_back('{mk(CMD_WRITE, 8'd1, 32'd200, 1'b0, 1'b0, 1'b1), 0, RULE_UNSIGNED});
		rows.push_back('{mk(CMD_CONNECT, 8'd1, 32'd201, 1'b0), 1, RULE_UNSIGNED});
		rows.push_back('{mk(CMD_CONNECT, 8'd2, 32'd0, 1'b0, 1'b0), 0, RULE_UNSIGNED});
		rows.push_back('{mk(CMD_EXIT, 8'd5, 32'd0), 0, RULE_UNSIGNED});
		rows.push_back('{mk(CMD_EXIT, 8'd0, 32'd300), 0, RULE_UNSIGNED});
		// Exec that migrates the tmp flag from another slot.
		rows.push_back('{mk(CMD_EXEC, 8'd3, 32'd205, 1'b0, 1'b0, 1'b0, 8'd1, 1'b1), 0,
			RULE_EXEC});
		rows.push_back('{mk(CMD_CONNECT, 8'd3, 32'd206, 1'b0), 1, RULE_UNSIGNED});
		rows.push_back('{mk(CMD_EXEC, 8'd4, 32'd300, 1'b1, 1'b0, 1'b0, 8'd4, 1'b1), 0,
			RULE_EXEC});
		// Time going backward between connects.
		rows.push_back('{mk(CMD_CONNECT, 8'd6, 32'hFFFF_FFFF), 0, RULE_UNSIGNED});
		rows.push_back('{mk(CMD_CONNECT, 8'd6, 32'd10), 0, RULE_UNSIGNED});
		rows.push_back('{mk(CMD_WRITE, 8'd255, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 8'd255,
			1'b1), 0, RULE_UNSIGNED});
		// A steady beacon with a 10 s period fires on the sixth connect.
		for (int i = 0; i < 6; i++)
			rows.push_back('{mk(CMD_CONNECT, 8'd7, 32'd1000 + 10 * i), (i == 5) ? 1 : 0,
				RULE_BEACON});
		foreach (rows[i]) begin
			send_event(rows[i].ev, n, r);
			if (n != rows[i].n_alerts)
				report($sformatf("row %0d gives %0d alerts, want %0d", i, n,
					rows[i].n_alerts));
			else if (n > 0 && r !== rows[i].first_rule)
				report($sformatf("row %0d first rule %0d, want %0d", i, r,
					rows[i].first_rule));
		end
		// The sender holds off here until every alert so far has come out.
		wait_idle();
		run_random(80);

		wait_idle();
		write_all(16'd1, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_idle = 48;
		recv_idle = 13;
		run_random(80);

		wait_idle();
		write_all(16'd1000, 16'hFFFF, 16'd7, 16'd100, 16'd1000, 16'hFFFF);
		run_random(80);

		wait_idle();
		write_all(16'($urandom_range(1, 8)), 16'($urandom_range(0, 40)),
			16'($urandom_range(1, 7)), 16'($urandom_range(0, 100)),
			16'($urandom_range(1, 12)), 16'($urandom_range(0, 60)));
		write_reg(REG_SPARE, 16'h5A5A);
		send_idle = 0;
		recv_idle = 0;
		run_random(90);

		wait_idle();
		$display("%0d events sent over four register settings, %0d alerts checked", items_sent,
			alerts_seen);
		$display("alerts by rule: unsigned %0d, exec %0d, beacon %0d, fan-out %0d",
			rule_hits[0], rule_hits[1], rule_hits[2], rule_hits[3]);
		if (errors == 0 && expected_alerts.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
`default_nettype wire
